// ===== hdl/pdqm_pkg.sv =====
// Shared constants, register indexes and the motor saturation function for the
// PPM decoder with quad-X mixer. No dependencies; imported by the top level.
package pdqm_pkg;

    // Number of PPM channels held in the width store.
    localparam int CHANNELS      = 9;
    localparam int CH_CNT_W      = $clog2(CHANNELS + 1);
    localparam int STORE_IDX_W   = $clog2(CHANNELS);

    // Field widths.
    localparam int TICK_W        = 16;
    localparam int CHAN_W        = 4;
    localparam int SCALE_W       = 8;
    localparam int MIX_W         = 19;
    localparam int PROD_W        = MIX_W + SCALE_W + 1;

    // Configuration port.
    localparam int CFG_IDX_W     = 3;
    localparam int CFG_DATA_W    = 16;

    localparam logic [CFG_IDX_W-1:0] REG_SYNC_GAP      = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_STICK_CENTER  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_PWM_SCALE     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_ARM_STICK_MAX = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_ARM_YAW_MIN   = 3'd4;

    // Register reset values.
    localparam logic [TICK_W-1:0]  SYNC_GAP_RST      = 16'd1000;
    localparam logic [TICK_W-1:0]  STICK_CENTER_RST  = 16'd300;
    localparam logic [SCALE_W-1:0] PWM_SCALE_RST     = 8'd5;
    localparam logic [TICK_W-1:0]  ARM_STICK_MAX_RST = 16'd205;
    localparam logic [TICK_W-1:0]  ARM_YAW_MIN_RST   = 16'd395;

    // Output packing: tdata width rounded up to whole bytes.
    localparam int OUT_BITS      = CHAN_W + TICK_W + 2 + 4 * TICK_W;
    localparam int OUT_DATA_W    = ((OUT_BITS + 7) / 8) * 8;

    typedef logic [TICK_W-1:0] tick_t;
    typedef logic signed [MIX_W-1:0] mix_t;

    // Scale a signed mixed value and clamp the result to 0..65535.
    function automatic tick_t sat_motor(input mix_t mix, input logic [SCALE_W-1:0] scale);
        logic signed [PROD_W-1:0] mix_ext;
        logic signed [PROD_W-1:0] scale_ext;
        logic signed [PROD_W-1:0] prod;
        tick_t                    res;
        mix_ext   = $signed({{(PROD_W-MIX_W){mix[MIX_W-1]}}, mix});
        scale_ext = $signed({{(PROD_W-SCALE_W){1'b0}}, scale});
        prod      = mix_ext * scale_ext;
        if (prod < 0)
        begin
            res = '0;
        end
        else if (prod > $signed({{(PROD_W-TICK_W){1'b0}}, {TICK_W{1'b1}}}))
        begin
            res = '1;
        end
        else
        begin
            res = prod[TICK_W-1:0];
        end
        return res;
    endfunction

endpackage

// ===== hdl/ppm_decode_quad_mixer_top.sv =====
// PPM decoder with quad-X motor mixer, top level.
// Depends on pdqm_pkg for constants, register indexes and the saturation function.
//
// Usage:
//   s_* carries one capture edge per transaction: s_tdata[15:0] holds the timer
//   ticks since the previous edge. m_* returns one result per edge: m_tuser is the
//   captured flag, m_tdata packs channel, width, sync_ok, armed and the four motor
//   compares. cfg_* writes one register per transaction (index, data); it is
//   always ready and must only be used while no edge is in flight.
//   m_tvalid is driven by the output register, so each result passes two
//   registers: the first holds the decoder state update, the second holds the
//   mixer output, which is one adder tree and one 19x8 multiply per motor.
//   Throughput is one edge per cycle while the receiver is ready. When the
//   receiver stalls, the output register and the decode stage both fill, and
//   s_tready drops after the second held edge; no result is lost or repeated.
//   Reset clears sync, edge phase, channel index and the channel widths, and sets
//   the configuration registers to their defaults; no clearing pass is needed.
module ppm_decode_quad_mixer_top
    import pdqm_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    // Capture edge input; tdata: interval_ticks[15:0].
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [TICK_W-1:0]      s_tdata,
    // Result output; tdata: channel[3:0], width[19:4], sync_ok[20], armed[21],
    // motor_one[37:22], motor_two[53:38], motor_three[69:54], motor_four[85:70], zero pad.
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [OUT_DATA_W-1:0]  m_tdata,
    // tuser: captured.
    output logic                   m_tuser,
    // Configuration write channel.
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_IDX_W-1:0]   cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data
);

    // Configuration registers.
    tick_t               sync_gap_reg;
    tick_t               stick_center_reg;
    logic [SCALE_W-1:0]  pwm_scale_reg;
    tick_t               arm_stick_max_reg;
    tick_t               arm_yaw_min_reg;

    // Decoder state.
    logic                synced_reg;
    logic                synced_next;
    logic                edge_phase_reg;
    logic                edge_phase_next;
    logic [CH_CNT_W-1:0] channel_index_reg;
    logic [CH_CNT_W-1:0] channel_index_next;
    tick_t               channel_store_reg [CHANNELS];
    logic                store_we;

    // Decode stage result.
    logic                s1_valid_reg;
    logic                s1_captured_reg;
    logic                s1_captured_next;
    logic [CHAN_W-1:0]   s1_channel_reg;
    logic [CHAN_W-1:0]   s1_channel_next;
    tick_t               s1_width_reg;
    tick_t               s1_width_next;
    logic                s1_synced_reg;

    // Output stage.
    logic                out_valid_reg;
    logic                out_captured_reg;
    logic [CHAN_W-1:0]   out_channel_reg;
    tick_t               out_width_reg;
    logic                out_synced_reg;
    logic                out_armed_reg;
    tick_t               out_motor_reg [4];
    logic                armed_next;
    tick_t               motor_next [4];

    logic                in_accept;
    logic                out_load;
    mix_t                center_val;
    mix_t                roll_val;
    mix_t                pitch_val;
    mix_t                thr_val;
    mix_t                yaw_val;

    // Handshake control: the decode stage moves on when the output register is free.
    assign out_load  = s1_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready  = !s1_valid_reg || out_load;
    assign in_accept = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;

    // Configuration register writes; unknown indexes are ignored.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sync_gap_reg      <= SYNC_GAP_RST;
            stick_center_reg  <= STICK_CENTER_RST;
            pwm_scale_reg     <= PWM_SCALE_RST;
            arm_stick_max_reg <= ARM_STICK_MAX_RST;
            arm_yaw_min_reg   <= ARM_YAW_MIN_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_SYNC_GAP:      sync_gap_reg      <= cfg_data;
                REG_STICK_CENTER:  stick_center_reg  <= cfg_data;
                REG_PWM_SCALE:     pwm_scale_reg     <= cfg_data[SCALE_W-1:0];
                REG_ARM_STICK_MAX: arm_stick_max_reg <= cfg_data;
                REG_ARM_YAW_MIN:   arm_yaw_min_reg   <= cfg_data;
                default:           ;
            endcase
        end
    end

    // Edge decoding: restart/measure alternation, sync search, channel capture and frame wrap.
    always_comb
    begin
        synced_next        = synced_reg;
        edge_phase_next    = edge_phase_reg;
        channel_index_next = channel_index_reg;
        store_we           = 1'b0;
        s1_captured_next   = 1'b0;
        s1_channel_next    = '0;
        s1_width_next      = '0;
        if (!synced_reg)
        begin
            edge_phase_next = !edge_phase_reg;
            if (edge_phase_reg && (s_tdata > sync_gap_reg))
            begin
                synced_next = 1'b1;
            end
        end
        else if (channel_index_reg < CH_CNT_W'(CHANNELS))
        begin
            edge_phase_next = !edge_phase_reg;
            if (edge_phase_reg)
            begin
                store_we           = 1'b1;
                s1_captured_next   = 1'b1;
                s1_channel_next    = CHAN_W'(channel_index_reg);
                s1_width_next      = s_tdata;
                channel_index_next = channel_index_reg + CH_CNT_W'(1);
            end
        end
        else
        begin
            // Frame wrap: the index returns to zero and nothing is stored.
            channel_index_next = '0;
        end
    end

    // Decoder state and channel width store.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            synced_reg        <= 1'b0;
            edge_phase_reg    <= 1'b0;
            channel_index_reg <= '0;
            for (int k = 0; k < CHANNELS; k++)
            begin
                channel_store_reg[k] <= '0;
            end
        end
        else if (in_accept)
        begin
            synced_reg        <= synced_next;
            edge_phase_reg    <= edge_phase_next;
            channel_index_reg <= channel_index_next;
            if (store_we)
            begin
                channel_store_reg[channel_index_reg[STORE_IDX_W-1:0]] <= s_tdata;
            end
        end
    end

    // Decode stage valid flag.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (in_accept)
        begin
            s1_valid_reg <= 1'b1;
        end
        else if (out_load)
        begin
            s1_valid_reg <= 1'b0;
        end
    end

    // Decode stage payload.
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            s1_captured_reg <= s1_captured_next;
            s1_channel_reg  <= s1_channel_next;
            s1_width_reg    <= s1_width_next;
            s1_synced_reg   <= synced_next;
        end
    end

    // Mixer and arming check, read from the store as left by the decode stage item.
    always_comb
    begin
        center_val = $signed({3'b000, stick_center_reg});
        roll_val   = $signed({3'b000, channel_store_reg[0]}) - center_val;
        pitch_val  = $signed({3'b000, channel_store_reg[1]}) - center_val;
        thr_val    = $signed({3'b000, channel_store_reg[2]});
        yaw_val    = $signed({3'b000, channel_store_reg[3]}) - center_val;
        motor_next[0] = sat_motor(roll_val - pitch_val + thr_val + yaw_val, pwm_scale_reg);
        motor_next[1] = sat_motor(roll_val + pitch_val + thr_val - yaw_val, pwm_scale_reg);
        motor_next[2] = sat_motor(thr_val - roll_val - pitch_val - yaw_val, pwm_scale_reg);
        motor_next[3] = sat_motor(thr_val - roll_val + pitch_val + yaw_val, pwm_scale_reg);
        armed_next = (channel_store_reg[0] <= arm_stick_max_reg) &&
                     (channel_store_reg[1] <= arm_stick_max_reg) &&
                     (channel_store_reg[2] <= arm_stick_max_reg) &&
                     (channel_store_reg[3] >= arm_yaw_min_reg);
    end

    // Output register valid flag.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // Output register payload.
    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_captured_reg <= s1_captured_reg;
            out_channel_reg  <= s1_channel_reg;
            out_width_reg    <= s1_width_reg;
            out_synced_reg   <= s1_synced_reg;
            out_armed_reg    <= armed_next;
            for (int k = 0; k < 4; k++)
            begin
                out_motor_reg[k] <= motor_next[k];
            end
        end
    end

    // Output packing.
    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_captured_reg;
    assign m_tdata  = OUT_DATA_W'({out_motor_reg[3], out_motor_reg[2], out_motor_reg[1],
                                   out_motor_reg[0], out_armed_reg, out_synced_reg,
                                   out_width_reg, out_channel_reg});

`ifndef ASSERT_OFF
    // The channel index never passes the wrap value.
    a_index_range: assert property (@(posedge clk) disable iff (!rst_n)
        channel_index_reg <= CH_CNT_W'(CHANNELS))
        else $error("channel index beyond channel count");

    // Sync, once found, is never lost.
    a_sync_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        synced_reg |=> synced_reg)
        else $error("sync flag cleared");

    // A captured result always reports sync.
    a_capture_synced: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser) |-> m_tdata[CHAN_W + TICK_W])
        else $error("capture reported without sync");

    // Input back-pressure only when both stages hold data and the receiver stalls.
    a_ready_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> (s1_valid_reg && m_tvalid && !m_tready))
        else $error("input stalled without a full pipeline");
`endif

endmodule

// ===== dv/ppm_decode_quad_mixer_top_tb.sv =====
// Self-checking testbench for the PPM decoder with quad-X mixer top level.
// Drives capture edges and register writes, predicts each result and checks it.
// Depends on pdqm_pkg and ppm_decode_quad_mixer_top.
module ppm_decode_quad_mixer_top_tb;

    timeunit 1ns;
    timeprecision 1ps;

    import pdqm_pkg::*;

    localparam int     CYCLE_LIMIT  = 400000;
    localparam int     DRAIN_CYCLES = 4;
    localparam int     IDLE_PCT     = 34;
    localparam int     MOTORS       = 4;
    localparam longint TICK_MAX     = 2 ** TICK_W - 1;

    // Bit positions inside m_tdata.
    localparam int WIDTH_LSB = CHAN_W;
    localparam int SYNC_BIT  = WIDTH_LSB + TICK_W;
    localparam int ARMED_BIT = SYNC_BIT + 1;
    localparam int MOTOR_LSB = ARMED_BIT + 1;

    typedef struct packed {
        logic                         captured;
        logic [CHAN_W-1:0]            channel;
        tick_t                        width;
        logic                         sync_ok;
        logic                         armed;
        logic [MOTORS-1:0][TICK_W-1:0] motor;
    } edge_result_t;

    logic                  clk       = 1'b0;
    logic                  rst_n     = 1'b0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [TICK_W-1:0]     s_tdata   = '0;
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [OUT_DATA_W-1:0] m_tdata;
    logic                  m_tuser;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;

    // Decoder state and registers as the block should hold them.
    logic                  frame_locked = 1'b0;
    logic                  measure_next = 1'b0;
    logic [CH_CNT_W-1:0]   slot         = '0;
    tick_t                 widths [CHANNELS] = '{default: '0};
    tick_t                 gap_limit     = SYNC_GAP_RST;
    tick_t                 center        = STICK_CENTER_RST;
    logic [SCALE_W-1:0]    scale         = PWM_SCALE_RST;
    tick_t                 stick_ceiling = ARM_STICK_MAX_RST;
    tick_t                 yaw_floor     = ARM_YAW_MIN_RST;

    edge_result_t          edge_results [$];
    int                    errors       = 0;
    logic                  calm         = 1'b0;
    logic                  arming_frame = 1'b0;

    ppm_decode_quad_mixer_top uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // Clock generation, 4 ns period.
    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // Scale one mixed value and clamp it to the compare range.
    function automatic tick_t motor_compare(input longint mix);
        longint v;
        v = mix * longint'(scale);
        if (v < 0)
            return '0;
        if (v > TICK_MAX)
            return '1;
        return v[TICK_W-1:0];
    endfunction

    // Advance the decoder by one capture edge and work out its result.
    function automatic edge_result_t decode_edge(input tick_t ticks);
        edge_result_t res;
        longint       c;
        longint       r;
        longint       p;
        longint       t;
        longint       y;
        res = '0;
        if (!frame_locked)
        begin
            if (!measure_next)
            begin
                measure_next = 1'b1;
            end
            else
            begin
                measure_next = 1'b0;
                if (ticks > gap_limit)
                    frame_locked = 1'b1;
            end
        end
        else if (slot < CHANNELS)
        begin
            if (!measure_next)
            begin
                measure_next = 1'b1;
            end
            else
            begin
                widths[slot] = ticks;
                res.captured = 1'b1;
                res.channel  = slot;
                res.width    = ticks;
                measure_next = 1'b0;
                slot         = slot + 1'b1;
            end
        end
        else
        begin
            // All channels stored: this edge only rewinds the index.
            slot = '0;
        end

        c = longint'(center);
        r = longint'(widths[0]) - c;
        p = longint'(widths[1]) - c;
        t = longint'(widths[2]);
        y = longint'(widths[3]) - c;
        res.sync_ok  = frame_locked;
        res.armed    = (widths[0] <= stick_ceiling) && (widths[1] <= stick_ceiling) &&
                       (widths[2] <= stick_ceiling) && (widths[3] >= yaw_floor);
        res.motor[0] = motor_compare(r - p + t + y);
        res.motor[1] = motor_compare(r + p + t - y);
        res.motor[2] = motor_compare(-r - p + t - y);
        res.motor[3] = motor_compare(-r + p + t + y);
        return res;
    endfunction

    // Mirror one register write; unknown indexes change nothing.
    function automatic void apply_reg(input logic [CFG_IDX_W-1:0] addr,
                                      input logic [CFG_DATA_W-1:0] data);
        case (addr)
            REG_SYNC_GAP:      gap_limit     = data;
            REG_STICK_CENTER:  center        = data;
            REG_PWM_SCALE:     scale         = data[SCALE_W-1:0];
            REG_ARM_STICK_MAX: stick_ceiling = data;
            REG_ARM_YAW_MIN:   yaw_floor     = data;
            default:           ;
        endcase
    endfunction

    // Random interval, biased toward stick values and the arming thresholds.
    function automatic tick_t pick_ticks();
        tick_t base;
        if (arming_frame && frame_locked && measure_next && slot < 4)
        begin
            if (slot == 3)
                return tick_t'($urandom_range(int'(TICK_MAX), int'(yaw_floor)));
            return tick_t'($urandom_range(int'(stick_ceiling), 0));
        end
        base = (slot == 3) ? yaw_floor : stick_ceiling;
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return '1;
            2, 3, 4: return tick_t'($urandom_range(0, int'(TICK_MAX)));
            5, 6:    return tick_t'(base + $urandom_range(0, 2) - 1);
            default: return tick_t'($urandom_range(100, 500));
        endcase
    endfunction

    function automatic void compare_field(input string name, input int unsigned want,
                                          input int unsigned got);
        if (want != got)
        begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            errors++;
        end
    endfunction

    // Hold the input side idle until every result has come back.
    task automatic wait_idle();
        s_tvalid <= 1'b0;
        while (edge_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // One register write transaction, issued only with the block idle.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] addr,
                             input logic [CFG_DATA_W-1:0] data);
        wait_idle();
        cfg_valid <= 1'b1;
        cfg_index <= addr;
        cfg_data  <= data;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        apply_reg(addr, data);
        @(posedge clk);
    endtask

    // One capture edge transaction, with a random gap in front of it.
    task automatic send_edge(input tick_t ticks);
        while (!calm && $urandom_range(0, 99) < IDLE_PCT)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= ticks;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        edge_results.push_back(decode_edge(ticks));
    endtask

    // Random edges; some frames are steered into the arming position.
    task automatic run_frames(input int count);
        for (int n = 0; n < count; n++)
        begin
            if (slot == CHANNELS)
                arming_frame = ($urandom_range(0, 99) < 40);
            send_edge(pick_ticks());
        end
    endtask

    // Edges before sync, including intervals equal to the threshold.
    task automatic test_unsynced_edges();
        // With the threshold at its top no interval can declare sync.
        write_reg(REG_SYNC_GAP, '1);
        send_edge('1);
        send_edge('1);
        write_reg(REG_SYNC_GAP, SYNC_GAP_RST);
        // A restart edge ignores its interval even above the threshold.
        send_edge(16'd2000);
        send_edge(SYNC_GAP_RST);
        send_edge('0);
        // Just above the threshold: sync is declared and nothing is stored.
        send_edge(SYNC_GAP_RST + 16'd1);
    endtask

    // One full frame with extreme widths, then the wrap edge.
    task automatic test_first_frame();
        tick_t frame [CHANNELS];
        frame = '{16'd0, 16'hFFFF, 16'd0, 16'hFFFF, 16'd1, 16'h5555, 16'hAAAA,
                  16'd300, 16'hFFFE};
        for (int k = 0; k < CHANNELS; k++)
        begin
            send_edge((k % 2 == 0) ? 16'hFFFF : 16'h0000);
            send_edge(frame[k]);
        end
        send_edge(16'h1234);
    endtask

    // Writes to indexes past the last register must have no effect.
    task automatic test_unknown_registers();
        for (int i = int'(REG_ARM_YAW_MIN) + 1; i < 2 ** CFG_IDX_W; i++)
            write_reg(CFG_IDX_W'(i), CFG_DATA_W'($urandom_range(0, int'(TICK_MAX))));
        run_frames(15);
    endtask

    // Program the mixer and arming registers, then run random frames.
    task automatic mixer_phase(input tick_t center_val, input logic [SCALE_W-1:0] scale_val,
                               input tick_t stick_val, input tick_t yaw_val,
                               input int count);
        logic [CFG_DATA_W-1:0] scale_word;
        // Upper bits of the scale word are junk and must be dropped.
        scale_word                = CFG_DATA_W'($urandom_range(0, int'(TICK_MAX)));
        scale_word[SCALE_W-1:0]   = scale_val;
        write_reg(REG_STICK_CENTER, center_val);
        write_reg(REG_PWM_SCALE, scale_word);
        write_reg(REG_ARM_STICK_MAX, stick_val);
        write_reg(REG_ARM_YAW_MIN, yaw_val);
        run_frames(count);
    endtask

    // Fixed settings, extremes among them.
    task automatic test_mixer_settings();
        mixer_phase(STICK_CENTER_RST, PWM_SCALE_RST, ARM_STICK_MAX_RST, ARM_YAW_MIN_RST, 45);
        mixer_phase(16'd300, 8'd0, 16'd205, 16'd395, 45);
        mixer_phase(16'd0, 8'd255, 16'hFFFF, 16'd0, 45);
        mixer_phase(16'hFFFF, 8'd255, 16'd0, 16'hFFFF, 45);
        mixer_phase(16'd1500, 8'd1, 16'd2000, 16'd1000, 45);
        mixer_phase(16'h8000, 8'd128, 16'd500, 16'd300, 45);
        mixer_phase(16'd100, 8'd37, 16'd150, 16'd450, 45);
    endtask

    // Random settings; the first phase runs with no idling on either side.
    task automatic test_random_settings();
        for (int n = 0; n < 3; n++)
        begin
            calm = (n == 0);
            write_reg(REG_SYNC_GAP, CFG_DATA_W'($urandom_range(0, int'(TICK_MAX))));
            mixer_phase(tick_t'($urandom_range(0, int'(TICK_MAX))),
                        SCALE_W'($urandom_range(0, 255)),
                        tick_t'($urandom_range(0, int'(TICK_MAX))),
                        tick_t'($urandom_range(0, int'(TICK_MAX))), 20);
            // Pause the sender until every result is back, then resume.
            wait_idle();
            run_frames(20);
        end
        calm = 1'b0;
    endtask

    // Output side: random back-pressure, none while the calm phase runs.
    always @(posedge clk)
        m_tready <= calm || ($urandom_range(0, 99) >= IDLE_PCT);

    // Compare each result transaction with the oldest prediction.
    always @(posedge clk)
    begin : check_output
        edge_result_t want;
        edge_result_t got;
        if (rst_n && m_tvalid && m_tready)
        begin
            got.captured = m_tuser;
            got.channel  = m_tdata[CHAN_W-1:0];
            got.width    = m_tdata[WIDTH_LSB +: TICK_W];
            got.sync_ok  = m_tdata[SYNC_BIT];
            got.armed    = m_tdata[ARMED_BIT];
            for (int k = 0; k < MOTORS; k++)
                got.motor[k] = m_tdata[MOTOR_LSB + k * TICK_W +: TICK_W];
            if (edge_results.size() == 0)
            begin
                $display("%0t: result with none pending, expected nothing, actual %h",
                         $time, m_tdata);
                errors++;
            end
            else
            begin
                want = edge_results.pop_front();
                compare_field("captured", 32'(want.captured), 32'(got.captured));
                compare_field("channel", 32'(want.channel), 32'(got.channel));
                compare_field("width", 32'(want.width), 32'(got.width));
                compare_field("sync_ok", 32'(want.sync_ok), 32'(got.sync_ok));
                compare_field("armed", 32'(want.armed), 32'(got.armed));
                for (int k = 0; k < MOTORS; k++)
                    compare_field($sformatf("motor %0d", k + 1), 32'(want.motor[k]),
                                  32'(got.motor[k]));
            end
        end
    end

    // Cycle counter that ends a hung run.
    initial
    begin : watchdog
        int cycles;
        cycles = 0;
        while (cycles < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("[FAIL] regression broken");
        $finish;
    end

    // Test sequence.
    initial
    begin
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_unsynced_edges();
        test_first_frame();
        test_unknown_registers();
        test_mixer_settings();
        test_random_settings();
        wait_idle();
        if (errors == 0 && edge_results.size() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
